// ----- hdl/bpr_pkg.sv -----
// Shared types, constants and helpers for the bitplane to RGB converter.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package bpr_pkg;

    localparam int GROUPS_PER_LINE = 20;
    localparam int LINES_PER_FRAME = 200;

    localparam int GROUP_W = (GROUPS_PER_LINE > 1) ? $clog2(GROUPS_PER_LINE) : 1;
    localparam int LINE_W  = 8;
    localparam int PIX_PER_GROUP = 16;
    localparam int PIX_W   = 4;
    localparam int NPLANES = 4;
    localparam int COLOR_W = 12;
    localparam int CHAN_W  = 16;
    localparam int WORD_W  = 16;
    localparam int ENTRY_W = 4;
    localparam int PAL_DEPTH = 16;

    localparam logic [ENTRY_W-1:0] ENTRY_SWITCH = 4'd0;
    localparam logic [ENTRY_W-1:0] ENTRY_LAST   = 4'd15;

    typedef enum logic [1:0] {
        OP_NEXT  = 2'd0,
        OP_GROUP = 2'd1,
        OP_CUR   = 2'd2
    } op_t;

    typedef struct packed {
        logic                valid;
        op_t                 op;
        logic [ENTRY_W-1:0]  entry;
        logic [WORD_W-1:0]   word;
    } cmd_t;

    // Rotate the top bit in below the low bit, then replicate to 16 bits.
    function automatic logic [CHAN_W-1:0] decode_nibble(input logic [3:0] n);
        logic [3:0] r;
        r = {n[2:0], n[3]};
        return {r, r, r, r};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/bitplane_to_rgb_with_line_palettes.sv -----
// Bitplane to RGB converter with per-scanline palette switching (top level).
// The first pixel of a plane group passes through the lane registers, then the output register.
// Throughput: one pixel per cycle while the receiver does not stall; the serializer's
// single palette read port sets that rate. Palette transfers wait for the serializer too.
// Reset (aresetn low, synchronous): counters, switch line (all ones) and handshake clear;
// palette contents are undefined until written.
`default_nettype none

module bitplane_to_rgb_with_line_palettes (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // [3:0] entry, [19:4] palette_word, [83:20] planes, pad
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [15:0] red, [31:16] green, [47:32] blue,
                                        // [51:48] color_index, pad
    output logic             m_tlast    // last pixel of a plane group
);

    bpr_pkg::cmd_t                       cmd;
    logic                                s_xfer;
    logic                                grp_load;
    logic [bpr_pkg::NPLANES*16-1:0]      planes;
    logic [bpr_pkg::NPLANES-1:0]         lane_idx [bpr_pkg::PIX_PER_GROUP];
    logic [bpr_pkg::ENTRY_W-1:0]         rd_idx;
    logic [bpr_pkg::COLOR_W-1:0]         rd_color;
    logic                                can_load;
    logic [bpr_pkg::CHAN_W-1:0]          red, green, blue;
    logic [bpr_pkg::NPLANES-1:0]         color_index;

    // Every transfer waits until the serializer is idle or moving out its final pixel, so palette
    // writes and switches never reach pixels of a group still being sent.
    assign s_tready = can_load;
    assign s_xfer   = s_tvalid && s_tready;

    // Unpack the input transfer.
    assign cmd.valid = s_xfer;
    assign cmd.op    = bpr_pkg::op_t'(s_tuser);
    assign cmd.entry = s_tdata[3:0];
    assign cmd.word  = s_tdata[19:4];
    assign planes    = s_tdata[83:20];

    assign grp_load  = s_xfer && (cmd.op == bpr_pkg::OP_GROUP);

    // Palettes, switch line and raster counters.
    bpr_palette u_palette (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .rd_color (rd_color)
    );

    // Sixteen lanes capture one pixel index each from the plane group.
    for (genvar g = 0; g < bpr_pkg::PIX_PER_GROUP; g++) begin : g_lane
        bpr_lane u_lane (
            .aclk    (aclk),
            .load    (grp_load),
            .planes  (planes),
            .pos     (bpr_pkg::PIX_W'(g)),
            .idx_reg (lane_idx[g])
        );
    end

    // Merge the lanes into one pixel per cycle, while the receiver does not stall, through the output register.
    bpr_serial u_serial (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (grp_load),
        .lane_idx      (lane_idx),
        .rd_idx        (rd_idx),
        .rd_color      (rd_color),
        .can_load      (can_load),
        .out_valid_reg (m_tvalid),
        .out_ready     (m_tready),
        .red_reg       (red),
        .green_reg     (green),
        .blue_reg      (blue),
        .index_reg     (color_index),
        .last_reg      (m_tlast)
    );

    // Pack the result transfer.
    assign m_tdata = {4'b0000, color_index, blue, green, red};

endmodule

`default_nettype wire

// ----- hdl/bpr_lane.sv -----
// One pixel lane: picks this lane's four plane bits out of a plane group and holds the index.
// Depends on bpr_pkg.
`default_nettype none

module bpr_lane (
    input  wire logic                                     aclk,
    input  wire logic                                     load,
    input  wire logic [bpr_pkg::NPLANES*16-1:0]           planes,
    input  wire logic [bpr_pkg::PIX_W-1:0]                pos,
    output logic      [bpr_pkg::NPLANES-1:0]              idx_reg
);

    logic [bpr_pkg::NPLANES-1:0] idx_next;

    // Pixel k sits at bit 15-k of each plane word.
    always_comb begin
        for (int j = 0; j < bpr_pkg::NPLANES; j++) begin
            idx_next[j] = planes[{2'(j), ~pos}];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bpr_palette.sv -----
// Current and next palettes, switch scanline, and the group and line counters.
// Depends on bpr_pkg; one combinational read port for the pixel serializer.
`default_nettype none

module bpr_palette (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire bpr_pkg::cmd_t                        cmd,
    input  wire logic [bpr_pkg::ENTRY_W-1:0]          rd_idx,
    output logic      [bpr_pkg::COLOR_W-1:0]          rd_color
);

    logic [bpr_pkg::COLOR_W-1:0] cur_pal_reg  [bpr_pkg::PAL_DEPTH];
    logic [bpr_pkg::COLOR_W-1:0] next_pal_reg [bpr_pkg::PAL_DEPTH];
    logic [bpr_pkg::WORD_W-1:0]  switch_line_reg, switch_line_next;
    logic                        next_ready_reg, next_ready_next;
    logic [bpr_pkg::LINE_W-1:0]  line_reg, line_next;
    logic [bpr_pkg::GROUP_W-1:0] group_reg, group_next;
    logic                        do_switch;

    assign rd_color = cur_pal_reg[rd_idx];

    // Switch only on the first group of the matching line, and only with the next palette armed.
    assign do_switch = cmd.valid && (cmd.op == bpr_pkg::OP_GROUP)
                       && (group_reg == '0) && next_ready_reg
                       && (switch_line_reg == bpr_pkg::WORD_W'(line_reg));

    always_comb begin
        switch_line_next = switch_line_reg;
        next_ready_next  = next_ready_reg;
        line_next        = line_reg;
        group_next       = group_reg;
        if (cmd.valid) begin
            case (cmd.op)
                bpr_pkg::OP_NEXT: begin
                    if (cmd.entry == bpr_pkg::ENTRY_SWITCH) begin
                        switch_line_next = cmd.word;
                        next_ready_next  = 1'b0;
                    end else if (cmd.entry == bpr_pkg::ENTRY_LAST) begin
                        next_ready_next  = 1'b1;
                    end
                end
                bpr_pkg::OP_GROUP: begin
                    if (do_switch) begin
                        next_ready_next = 1'b0;
                    end
                    if (group_reg == bpr_pkg::GROUP_W'(bpr_pkg::GROUPS_PER_LINE - 1)) begin
                        group_next = '0;
                        if (line_reg == bpr_pkg::LINE_W'(bpr_pkg::LINES_PER_FRAME - 1)) begin
                            line_next = '0;
                        end else begin
                            line_next = line_reg + 1'b1;
                        end
                    end else begin
                        group_next = group_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            switch_line_reg <= '1;
            next_ready_reg  <= 1'b0;
            line_reg        <= '0;
            group_reg       <= '0;
        end else begin
            switch_line_reg <= switch_line_next;
            next_ready_reg  <= next_ready_next;
            line_reg        <= line_next;
            group_reg       <= group_next;
        end
    end

    // Palette storage; entry 0 of the current palette is never switched.
    always_ff @(posedge aclk) begin
        if (cmd.valid && (cmd.op == bpr_pkg::OP_CUR)) begin
            cur_pal_reg[cmd.entry] <= cmd.word[bpr_pkg::COLOR_W-1:0];
        end else if (do_switch) begin
            for (int e = 1; e < bpr_pkg::PAL_DEPTH; e++) begin
                cur_pal_reg[e] <= next_pal_reg[e];
            end
        end
        if (cmd.valid && (cmd.op == bpr_pkg::OP_NEXT)
            && (cmd.entry != bpr_pkg::ENTRY_SWITCH)) begin
            next_pal_reg[cmd.entry] <= cmd.word[bpr_pkg::COLOR_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bpr_serial.sv -----
// Merge stage: walks the sixteen lane indices, looks each up and decodes it into the output register.
// Depends on bpr_pkg; reads the palette through bpr_palette's read port.
`default_nettype none

module bpr_serial (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  load,
    input  wire logic [bpr_pkg::NPLANES-1:0]           lane_idx [bpr_pkg::PIX_PER_GROUP],
    output logic      [bpr_pkg::ENTRY_W-1:0]           rd_idx,
    input  wire logic [bpr_pkg::COLOR_W-1:0]           rd_color,
    output logic                                       can_load,
    output logic                                       out_valid_reg,
    input  wire logic                                  out_ready,
    output logic      [bpr_pkg::CHAN_W-1:0]            red_reg,
    output logic      [bpr_pkg::CHAN_W-1:0]            green_reg,
    output logic      [bpr_pkg::CHAN_W-1:0]            blue_reg,
    output logic      [bpr_pkg::NPLANES-1:0]           index_reg,
    output logic                                       last_reg
);

    logic                       busy_reg, busy_next;
    logic [bpr_pkg::PIX_W-1:0]  cnt_reg, cnt_next;
    logic                       out_valid_next;
    logic                       advance;
    logic                       final_pix;

    assign rd_idx    = lane_idx[cnt_reg];
    assign advance   = busy_reg && (!out_valid_reg || out_ready);
    assign final_pix = (cnt_reg == bpr_pkg::PIX_W'(bpr_pkg::PIX_PER_GROUP - 1));
    // Take a new transfer when idle, or once the last pixel of the group moves out this cycle.
    assign can_load  = !busy_reg || (advance && final_pix);

    always_comb begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            cnt_next       = cnt_reg + 1'b1;
            if (final_pix) begin
                busy_next = 1'b0;
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        if (load) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            red_reg   <= bpr_pkg::decode_nibble(rd_color[11:8]);
            green_reg <= bpr_pkg::decode_nibble(rd_color[7:4]);
            blue_reg  <= bpr_pkg::decode_nibble(rd_color[3:0]);
            index_reg <= rd_idx;
            last_reg  <= final_pix;
        end
    end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for bitplane_to_rgb_with_line_palettes: drives palette words and plane
// groups, predicts every pixel of every group and compares the result stream field by field.
// Depends on hdl/bpr_pkg.sv and hdl/bitplane_to_rgb_with_line_palettes.sv.

module tb_top;

    // Opcode the block must ignore; the package names only the three live ones.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 32;   // extra watch after the queue empties, for stray pixels
    localparam int MAX_REPORTS     = 40;   // keep the log short on a badly broken build
    localparam int ITEMS_PER_PHASE = 80;

    // Pixel index k of the group in pixel k, and its mirror image.
    localparam logic [63:0] RAMP_UP   = {16'h00FF, 16'h0F0F, 16'h3333, 16'h5555};
    localparam logic [63:0] RAMP_DOWN = ~RAMP_UP;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [3:0]  color_index;
        logic        last;
    } pixel_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;   // [3:0] entry, [19:4] palette_word, [83:20] planes, pad
    logic [1:0]  s_tuser  = '0;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // [15:0] red, [31:16] green, [47:32] blue,
                                  // [51:48] color_index, pad
    logic        m_tlast;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int items_sent    = 0;

    // Predicted state of the converter, advanced on every accepted input transfer.
    logic [11:0] cur_pal [bpr_pkg::PAL_DEPTH];
    logic [11:0] nxt_pal [bpr_pkg::PAL_DEPTH];
    logic [15:0] switch_line = 16'hFFFF;
    bit          next_armed  = 1'b0;
    int          line_cnt    = 0;
    int          group_cnt   = 0;

    // Pixels still owed by the block, oldest first.
    pixel_t pixel_q [$];

    bitplane_to_rgb_with_line_palettes u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop: a hung handshake or a missing pixel ends up here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle at the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Rotate the top bit in below the low bit, then spread the nibble over 16 bits.
    function automatic logic [15:0] channel_level(input logic [3:0] n);
        logic [15:0] rotated;
        rotated = {12'd0, n[2:0], n[3]};
        return rotated * 16'h1111;
    endfunction

    // Advance the predicted state by one input transfer; queue the pixels of a plane group.
    function automatic void predict_transfer(input logic [1:0] op, input logic [3:0] entry,
                                             input logic [15:0] word, input logic [63:0] planes);
        pixel_t      px;
        logic [3:0]  idx;
        logic [11:0] color;
        int          k;
        int          j;
        int          e;
        case (op)
            bpr_pkg::OP_NEXT: begin
                // Entry 0 carries the switch line only; its color is never used.
                if (entry == bpr_pkg::ENTRY_SWITCH) begin
                    switch_line = word;
                    next_armed  = 1'b0;
                end else begin
                    nxt_pal[entry] = word[11:0];
                    if (entry == bpr_pkg::ENTRY_LAST)
                        next_armed = 1'b1;
                end
            end
            bpr_pkg::OP_CUR: cur_pal[entry] = word[11:0];
            bpr_pkg::OP_GROUP: begin
                // Take over the armed palette at the first group of the matching line.
                // Current entry 0 survives the switch, and the palette is disarmed.
                if (group_cnt == 0 && next_armed && int'(switch_line) == line_cnt) begin
                    for (e = 1; e < bpr_pkg::PAL_DEPTH; e++)
                        cur_pal[e] = nxt_pal[e];
                    next_armed = 1'b0;
                end
                for (k = 0; k < bpr_pkg::PIX_PER_GROUP; k++) begin
                    for (j = 0; j < bpr_pkg::NPLANES; j++)
                        idx[j] = planes[16 * j + 15 - k];
                    color          = cur_pal[idx];
                    px.red         = channel_level(color[11:8]);
                    px.green       = channel_level(color[7:4]);
                    px.blue        = channel_level(color[3:0]);
                    px.color_index = idx;
                    px.last        = (k == bpr_pkg::PIX_PER_GROUP - 1);
                    pixel_q.push_back(px);
                end
                group_cnt++;
                if (group_cnt == bpr_pkg::GROUPS_PER_LINE) begin
                    group_cnt = 0;
                    line_cnt  = (line_cnt + 1) % bpr_pkg::LINES_PER_FRAME;
                end
            end
            default: ;  // unused opcode: no result, no state change
        endcase
    endfunction

    // Input monitor and result checker. Predict first, so a transfer's pixels are queued
    // before any of them can show up.
    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready === 1'b1)
                predict_transfer(s_tuser, s_tdata[3:0], s_tdata[19:4], s_tdata[83:20]);
            if (m_tvalid === 1'b1 && m_tready) begin
                got.red         = m_tdata[15:0];
                got.green       = m_tdata[31:16];
                got.blue        = m_tdata[47:32];
                got.color_index = m_tdata[51:48];
                got.last        = m_tlast;
                if (pixel_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected pixel: expected none, got r=%h g=%h b=%h",
                                 $time, got.red, got.green, got.blue,
                                 " idx=%h last=%b", got.color_index, got.last);
                end else begin
                    want = pixel_q.pop_front();
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: pixel mismatch: expected r=%h g=%h b=%h idx=%h last=%b",
                                     $time, want.red, want.green, want.blue,
                                     want.color_index, want.last,
                                     ", got r=%h g=%h b=%h idx=%h last=%b",
                                     got.red, got.green, got.blue, got.color_index, got.last);
                    end
                end
            end
        end
    end

    // Send one input transfer. Call at a falling edge; returns at the falling edge after
    // the transfer, with tvalid still high so back-to-back items need no second write.
    task automatic send_item(input logic [1:0] op, input logic [3:0] entry,
                             input logic [15:0] word, input logic [63:0] planes);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, planes, word, entry};
        @(posedge aclk);
        while (s_tready !== 1'b1)
            @(posedge aclk);
        if (op != OP_UNUSED)
            items_sent++;
        @(negedge aclk);
    endtask

    // Palette words carry junk in the plane field, plane groups junk in entry and word.
    task automatic send_palette(input logic [1:0] op, input logic [3:0] entry,
                                input logic [15:0] word);
        send_item(op, entry, word, {$urandom, $urandom});
    endtask

    task automatic send_group(input logic [63:0] planes);
        send_item(bpr_pkg::OP_GROUP, 4'($urandom), 16'($urandom), planes);
    endtask

    function automatic logic [63:0] random_planes();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic run_groups(input int count);
        repeat (count) send_group(random_planes());
    endtask

    // Arm a switch for line 0 right out of reset: the first group takes the next palette
    // over before its lookup, while current entry 0 keeps its own color.
    task automatic test_line_switch();
        int e;
        send_palette(bpr_pkg::OP_CUR, 4'd0, 16'hFA5C);
        send_palette(bpr_pkg::OP_NEXT, bpr_pkg::ENTRY_SWITCH, 16'h0000);
        for (e = 1; e < bpr_pkg::PAL_DEPTH; e++)
            send_palette(bpr_pkg::OP_NEXT, 4'(e),
                         {4'($urandom), 4'(e), 4'(15 - e), 4'(e) ^ 4'hA});
        send_group(RAMP_UP);
        send_group(RAMP_DOWN);
    endtask

    // Every nibble value in the red and green channels and all but 5 and A in blue, the all-zero
    // and all-one words, and masking of the unused top nibble.
    task automatic test_palette_decode();
        int          e;
        logic [15:0] word;
        for (e = 0; e < bpr_pkg::PAL_DEPTH; e++) begin
            word = {4'($urandom), 4'(15 - e), 4'(e), 4'(e) ^ 4'h5};
            if (e == 0)
                word = 16'h0000;
            else if (e == bpr_pkg::PAL_DEPTH - 1)
                word = 16'hFFFF;
            send_palette(bpr_pkg::OP_CUR, 4'(e), word);
        end
        send_group(64'h0);
        send_group('1);
        send_group(RAMP_UP);
        send_group(RAMP_DOWN);
    endtask

    // Opcode 3 must not write either palette or produce pixels.
    task automatic test_unused_op();
        send_palette(OP_UNUSED, 4'd0, 16'h0000);
        send_palette(OP_UNUSED, 4'd7, 16'h0123);
        send_palette(OP_UNUSED, 4'd15, 16'hFFFF);
        send_group(RAMP_UP);
    endtask

    // Mostly armed-switch sequences aimed at the next line or the one after, with random
    // colors and plane data; the rest is stray palette words, opcode 3 and short bursts.
    task automatic test_random_traffic(input int n_items);
        int          first;
        int          pick;
        int          target;
        int          count;
        logic [15:0] word;
        first = items_sent;
        while (items_sent - first < n_items) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                target = (line_cnt + 1 + $urandom_range(1)) % bpr_pkg::LINES_PER_FRAME;
                case ($urandom_range(5))
                    0:       word = 16'(target) | 16'h8000;  // high bits set: never matches
                    1:       word = 16'(target) | 16'h0100;  // just past the 8-bit line range
                    2:       word = 16'($urandom);
                    default: word = 16'(target);
                endcase
                send_palette(bpr_pkg::OP_NEXT, bpr_pkg::ENTRY_SWITCH, word);
                repeat ($urandom_range(6))
                    send_palette(bpr_pkg::OP_NEXT, 4'($urandom_range(1, 14)), 16'($urandom));
                send_palette(bpr_pkg::OP_NEXT, bpr_pkg::ENTRY_LAST, 16'($urandom));
                count = bpr_pkg::GROUPS_PER_LINE - group_cnt + $urandom_range(1, 24);
                run_groups(count);
            end else if (pick < 70) begin
                send_palette(bpr_pkg::OP_CUR, 4'($urandom), 16'($urandom));
            end else if (pick < 80) begin
                send_palette(OP_UNUSED, 4'($urandom), 16'($urandom));
            end else if (pick < 88) begin
                send_palette(bpr_pkg::OP_NEXT, 4'($urandom), 16'($urandom));
            end else begin
                run_groups($urandom_range(1, 6));
            end
        end
    endtask

    initial begin
        // Hold reset low, release it at a falling edge and start driving.
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Sender mostly busy, receiver mostly stalling.
        send_idle_pct = 17;
        recv_idle_pct = 66;
        test_line_switch();
        test_palette_decode();
        test_unused_op();
        test_random_traffic(ITEMS_PER_PHASE);

        // Sender mostly idle, receiver mostly ready.
        send_idle_pct = 66;
        recv_idle_pct = 17;
        test_random_traffic(ITEMS_PER_PHASE);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(ITEMS_PER_PHASE);

        s_tvalid <= 1'b0;
        // Drain the owed pixels, then watch a little longer for stray ones.
        while (pixel_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/bpr_pkg.sv
hdl/bpr_lane.sv
hdl/bpr_palette.sv
hdl/bpr_serial.sv
hdl/bitplane_to_rgb_with_line_palettes.sv
bench/tb_top.sv
